### src/dfer_pkg.sv
package dfer_pkg;

  localparam int BLOCK_SAMPLES    = 512;
  localparam int DELAY_BLOCKS_MAX = 64;
  localparam int TAP_COUNT        = 8;
  localparam int LINE_DEPTH       = BLOCK_SAMPLES * DELAY_BLOCKS_MAX;
  localparam int PTR_W            = $clog2(LINE_DEPTH);
  localparam int SAMPLE_W         = 16;
  localparam int ECHO_W           = 24;
  localparam int COEF_W           = 8;
  localparam int DELAY_W          = 6;
  localparam int VOL_W            = 7;
  localparam int CFG_DATA_W       = 64;
  localparam int CFG_IDX_W        = 2;
  localparam int TAP_IDX_W        = $clog2(TAP_COUNT + 1);
  // product width: 24-bit operand by 8-bit operand
  localparam int PROD_W           = ECHO_W + COEF_W;
  localparam int ACC_W            = ECHO_W + 6;
  localparam int MULT_CNT_W       = $clog2(COEF_W + 1);

  localparam logic [CFG_IDX_W-1:0] REG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_TAP,
    ST_MIX,
    ST_OUT
  } state_t;

  // multiplier handshake
  typedef struct packed {
    logic start;
  } mul_ctl_t;

  typedef struct packed {
    logic done;
  } mul_sts_t;

endpackage

### src/delayed_fir_echo_reverb_unit.sv
// Channel | Ports                                     | Direction
// in      | in_valid, in_stall, in_sample_in[15:0]    | sample beat in
// out     | out_valid, out_stall, out_mixed_out[23:0] | mixed beat out
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | register write
// Ten multiplies per sample (eight taps, feedback, volume) on the shared
// bit-serial multiplier, one after another; no new sample is taken while a
// sample is in flight.
// Reset and every register write start a clearing pass of the whole
// delay line, one entry a cycle, during which no input is taken.
// out_stall holds the result; the next sample waits until it has left.
module delayed_fir_echo_reverb_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [dfer_pkg::SAMPLE_W-1:0]   in_sample_in,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [dfer_pkg::ECHO_W-1:0]     out_mixed_out,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dfer_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dfer_pkg::CFG_DATA_W-1:0]        cfg_data
);

  import dfer_pkg::*;

  state_t state_r, state_nxt;

  logic [DELAY_W-1:0]      delay_r;
  logic [CFG_DATA_W-1:0]   coef_r;
  logic signed [COEF_W-1:0] gain_r;
  logic [VOL_W-1:0]        volume_r;

  logic [PTR_W-1:0]        wptr_r, rptr_r, clr_r;
  logic [PTR_W:0]          clr_cnt_r;
  logic signed [SAMPLE_W-1:0] win_r [TAP_COUNT];
  logic signed [SAMPLE_W-1:0] x_r;
  logic signed [ECHO_W-1:0] echo_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [TAP_IDX_W-1:0]     tap_r;
  logic                     busy_r;
  logic                     out_valid_r;
  logic signed [ECHO_W-1:0] out_r;

  logic                     cfg_fire, in_fire;
  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  logic [SAMPLE_W-1:0]      ram_wdata, ram_rdata;
  logic [PTR_W-1:0]         rst_rptr;

  mul_ctl_t                 mctl;
  mul_sts_t                 msts;
  logic signed [ECHO_W-1:0] mcand;
  logic signed [COEF_W-1:0] mplier;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] quot;
  logic signed [ACC_W+1:0]  acc_sum;
  logic signed [ECHO_W-1:0] echo_sat;
  logic signed [ACC_W-1:0]  mix_sum;
  logic signed [ECHO_W-1:0] mix_sat;

  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || out_valid_r;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_mixed_out = out_r;

  // read pointer after restart
  always_comb begin
    if (delay_r == '0) begin
      rst_rptr = '0;
    end else begin
      rst_rptr = PTR_W'((DELAY_BLOCKS_MAX - int'(delay_r)) * BLOCK_SAMPLES);
    end
  end

  // delay line memory
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr_r;
    ram_wdata = in_sample_in;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (in_fire) begin
      ram_we = 1'b1;
    end
  end

  dfer_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rptr_r),
    .rdata (ram_rdata)
  );

  // multiplier operand select: taps, then feedback, then volume
  always_comb begin
    if (tap_r < TAP_IDX_W'(TAP_COUNT)) begin
      mcand  = ECHO_W'(win_r[tap_r[TAP_IDX_W-2:0]]);
      mplier = coef_r[tap_r[TAP_IDX_W-2:0]*COEF_W +: COEF_W];
    end else if (state_r == ST_TAP) begin
      mcand  = echo_r;
      mplier = gain_r;
    end else begin
      mcand  = echo_r;
      mplier = COEF_W'({1'b0, volume_r});
    end
  end

  dfer_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mctl),
    .mcand  (mcand),
    .mplier (mplier),
    .sts    (msts),
    .prod   (prod)
  );

  // truncate toward zero: bias negatives by 127 before the shift
  assign quot = (prod + (prod[PROD_W-1] ? PROD_W'(127) : PROD_W'(0))) >>> 7;
  assign acc_sum = (ACC_W+2)'(acc_r) + (ACC_W+2)'(quot);
  always_comb begin
    if (acc_sum > (ACC_W+2)'(8388607)) begin
      echo_sat = 24'sh7FFFFF;
    end else if (acc_sum < -(ACC_W+2)'(8388608)) begin
      echo_sat = -24'sh800000;
    end else begin
      echo_sat = ECHO_W'(acc_sum);
    end
  end
  assign mix_sum = ACC_W'(x_r) + ACC_W'(quot);
  always_comb begin
    if (mix_sum > ACC_W'(8388607)) begin
      mix_sat = 24'sh7FFFFF;
    end else if (mix_sum < -ACC_W'(8388608)) begin
      mix_sat = -24'sh800000;
    end else begin
      mix_sat = ECHO_W'(mix_sum);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == (PTR_W+1)'(LINE_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_fire) state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_TAP;
      ST_TAP:   if (msts.done && tap_r == TAP_IDX_W'(TAP_COUNT)) state_nxt = ST_MIX;
      ST_MIX:   if (msts.done) state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
    if (cfg_fire) state_nxt = ST_CLEAR;
  end

  // multiplier start
  always_comb begin
    mctl.start = 1'b0;
    case (state_r)
      ST_TAP, ST_MIX: mctl.start = !busy_r;
      default:        mctl.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      delay_r     <= '0;
      coef_r      <= '0;
      gain_r      <= '0;
      volume_r    <= VOL_W'(127);
      wptr_r      <= '0;
      rptr_r      <= '0;
      clr_r       <= '0;
      clr_cnt_r   <= '0;
      echo_r      <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      tap_r       <= '0;
      for (int i = 0; i < TAP_COUNT; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          // a register write restarts the pass below
          if (!cfg_fire) begin
            clr_r     <= clr_r + 1'b1;
            clr_cnt_r <= clr_cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            x_r <= in_sample_in;
          end
        end
        ST_READ: begin
          // memory data for rptr is now valid; a same-cycle write to rptr is bypassed from x_r
          for (int i = 0; i + 1 < TAP_COUNT; i++) win_r[i] <= win_r[i+1];
          win_r[TAP_COUNT-1] <= (wptr_r == rptr_r) ? x_r : ram_rdata;
          wptr_r <= wptr_r + 1'b1;
          rptr_r <= rptr_r + 1'b1;
          tap_r  <= '0;
          acc_r  <= '0;
          busy_r <= 1'b0;
        end
        ST_TAP: begin
          if (!busy_r) busy_r <= 1'b1;
          if (msts.done) begin
            busy_r <= 1'b0;
            tap_r  <= tap_r + 1'b1;
            if (tap_r == TAP_IDX_W'(TAP_COUNT)) begin
              echo_r <= echo_sat;
            end else begin
              acc_r <= ACC_W'(acc_sum);
            end
          end
        end
        ST_MIX: begin
          if (!busy_r) busy_r <= 1'b1;
          if (msts.done) begin
            busy_r <= 1'b0;
            out_r  <= mix_sat;
          end
        end
        ST_OUT: begin
          out_valid_r <= 1'b1;
        end
        default: ;
      endcase
      if (cfg_fire) begin
        case (cfg_index)
          REG_DELAY:  delay_r  <= cfg_data[DELAY_W-1:0];
          REG_COEF:   coef_r   <= cfg_data;
          REG_GAIN:   gain_r   <= cfg_data[COEF_W-1:0];
          REG_VOLUME: volume_r <= cfg_data[VOL_W-1:0];
          default: ;
        endcase
        clr_r     <= '0;
        clr_cnt_r <= '0;
        wptr_r    <= '0;
        echo_r    <= '0;
        busy_r    <= 1'b0;
        for (int i = 0; i < TAP_COUNT; i++) win_r[i] <= '0;
      end
      if (state_r == ST_CLEAR && state_nxt == ST_IDLE) begin
        rptr_r <= rst_rptr;
      end
    end
  end

endmodule

### src/dfer_ram.sv
module dfer_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/dfer_mul.sv
// Serial signed multiplier: signed 24-bit multiplicand by signed 8-bit
// multiplier, one multiplier bit per cycle (shift-add, last bit subtracts).
module dfer_mul (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  dfer_pkg::mul_ctl_t                           ctl,
  input  logic signed [dfer_pkg::ECHO_W-1:0]           mcand,
  input  logic signed [dfer_pkg::COEF_W-1:0]           mplier,
  output dfer_pkg::mul_sts_t                           sts,
  output logic signed [dfer_pkg::PROD_W-1:0]           prod
);

  import dfer_pkg::*;

  logic [MULT_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic [COEF_W-1:0]         bits_r, bits_nxt;
  logic signed [PROD_W-1:0]  acc_r, acc_nxt;
  logic signed [PROD_W-1:0]  shifted;
  logic signed [PROD_W-1:0]  term;
  logic                      done_r, done_nxt;

  // multiplicand shifted to the current bit weight
  assign shifted = PROD_W'(mcand) <<< cnt_r;
  assign term    = (cnt_r == MULT_CNT_W'(COEF_W - 1)) ? -shifted : shifted;

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    bits_nxt = bits_r;
    acc_nxt  = acc_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      bits_nxt = mplier;
      acc_nxt  = '0;
    end else if (busy_r) begin
      if (bits_r[0]) begin
        acc_nxt = acc_r + term;
      end
      bits_nxt = bits_r >> 1;
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == MULT_CNT_W'(COEF_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bits_r <= bits_nxt;
    acc_r  <= acc_nxt;
  end

  assign sts.done = done_r;
  assign prod     = acc_r;

endmodule

### verif/delayed_fir_echo_reverb_unit_tb.sv
`timescale 1ns / 100ps

module delayed_fir_echo_reverb_unit_tb;
  import dfer_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int DRAIN_WAIT  = 300;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [ECHO_W-1:0]   out_mixed_out;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_data;

  delayed_fir_echo_reverb_unit i_dut (.*);

  // directed rows
  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    bit                         known;
    logic signed [ECHO_W-1:0]   mixed;
  } sample_row_t;

  // echo model state and register shadow
  logic [SAMPLE_W-1:0]      echo_line [LINE_DEPTH];
  longint                   tap_hist [TAP_COUNT];
  longint                   echo_last;
  longint                   echo_now;
  int unsigned              wr_ptr;
  int unsigned              rd_ptr;
  logic [DELAY_W-1:0]       delay_q;
  logic [CFG_DATA_W-1:0]    coef_q;
  logic signed [COEF_W-1:0] gain_q;
  logic [VOL_W-1:0]         vol_q;

  logic signed [ECHO_W-1:0] mix_expected [$];
  int                       err_cnt = 0;
  int                       cycle_cnt = 0;
  int                       burst_left;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clip24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  function automatic void restart_echo();
    for (int i = 0; i < LINE_DEPTH; i++) echo_line[i] = '0;
    for (int i = 0; i < TAP_COUNT; i++) tap_hist[i] = 0;
    echo_last = 0;
    echo_now  = 0;
    wr_ptr    = 0;
    if (delay_q == 0) rd_ptr = 0;
    else rd_ptr = ((DELAY_BLOCKS_MAX - delay_q) * BLOCK_SAMPLES) % LINE_DEPTH;
  endfunction

  // one sample through the echo path
  function automatic logic signed [ECHO_W-1:0] mix_sample(logic signed [SAMPLE_W-1:0] s);
    longint acc;
    longint c;
    acc = 0;
    for (int i = 0; i < TAP_COUNT - 1; i++) tap_hist[i] = tap_hist[i+1];
    echo_line[wr_ptr] = s;
    tap_hist[TAP_COUNT-1] = longint'($signed(echo_line[rd_ptr]));
    echo_last = echo_now;
    for (int i = 0; i < TAP_COUNT; i++) begin
      c = longint'($signed(coef_q[8*i +: 8]));
      acc += (tap_hist[i] * c) / 128;
    end
    acc += (echo_last * longint'(gain_q)) / 128;
    echo_now = clip24(acc);
    wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
    rd_ptr = (rd_ptr + 1) % LINE_DEPTH;
    return ECHO_W'(clip24(longint'(s) + (echo_now * longint'(vol_q)) / 128));
  endfunction

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'sh7fff;
    if (r < 20) return -16'sh8000;
    if (r < 25) return '0;
    return SAMPLE_W'($urandom);
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("[%0d] %s: got %0d expected %0d", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // send one beat; expectation recorded on acceptance
  task automatic send_sample(logic signed [SAMPLE_W-1:0] s, bit known = 0,
                             logic signed [ECHO_W-1:0] typed = '0);
    int gap;
    logic signed [ECHO_W-1:0] pred;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= s;
    do @(posedge clk); while (in_stall);
    pred = mix_sample(s);
    mix_expected.push_back(known ? typed : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DELAY:  delay_q = data[DELAY_W-1:0];
      REG_COEF:   coef_q  = data;
      REG_GAIN:   gain_q  = data[COEF_W-1:0];
      REG_VOLUME: vol_q   = data[VOL_W-1:0];
      default: ;
    endcase
    restart_echo();
  endtask

  function automatic logic [CFG_DATA_W-1:0] junk_high(int keep, longint val);
    logic [CFG_DATA_W-1:0] d;
    d = {$urandom, $urandom};
    d = (d >> keep) << keep;
    return d | (CFG_DATA_W'(val) & ((64'd1 << keep) - 1));
  endfunction

  task automatic run_random(int n, bit pause_mid = 0);
    for (int i = 0; i < n; i++) begin
      if (pause_mid && i == n / 2) wait_drained();
      send_sample(pick_sample());
    end
  endtask

  // result check and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (mix_expected.size() == 0) begin
        report_mismatch("unexpected mixed_out", out_mixed_out, 0);
      end else begin
        if (out_mixed_out !== mix_expected[0])
          report_mismatch("mixed_out", out_mixed_out, mix_expected[0]);
        void'(mix_expected.pop_front());
      end
    end
    if (burst_left > 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 :
                      (($urandom_range(0, 199) == 0) ? 1'b1 : 1'b0);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("delayed_fir_echo_reverb_unit: mismatch");
      $finish;
    end
  end

  initial begin
    sample_row_t rows [$];
    rows = '{
      '{16'sh0000, 1, 24'sh000000}, '{16'sh7fff, 1, 24'sh007fff},
      '{-16'sh8000, 1, -24'sh008000}, '{-16'sh0001, 1, -24'sh000001},
      '{16'sh0001, 1, 24'sh000001}, '{16'sh5555, 1, 24'sh005555},
      '{-16'sh5556, 1, -24'sh005556}, '{16'sh0100, 1, 24'sh000100},
      '{16'sh7ffe, 1, 24'sh007ffe}, '{-16'sh7fff, 1, -24'sh007fff},
      '{16'sh0080, 1, 24'sh000080}, '{-16'sh0080, 1, -24'sh000080},
      '{16'sh1234, 0, '0}, '{-16'sh4321, 0, '0},
      '{16'sh7fff, 0, '0}, '{16'sh7fff, 0, '0},
      '{-16'sh8000, 0, '0}, '{-16'sh8000, 0, '0},
      '{16'sh0000, 0, '0}, '{16'sh2aaa, 0, '0}
    };
    burst_left   = 0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DELAY;
    cfg_data     = '0;
    delay_q      = '0;
    coef_q       = '0;
    gain_q       = '0;
    vol_q        = 7'd127;
    restart_echo();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // after reset no echo: output equals input
    foreach (rows[i]) send_sample(rows[i].sample, rows[i].known, rows[i].mixed);

    // largest taps and feedback, full volume: saturation
    write_reg(REG_DELAY, junk_high(DELAY_W, 0));
    write_reg(REG_COEF, 64'h7f7f_7f7f_7f7f_7f7f);
    write_reg(REG_GAIN, junk_high(COEF_W, 127));
    write_reg(REG_VOLUME, junk_high(VOL_W, 127));
    run_random(200);

    // most negative taps and feedback, zero volume
    write_reg(REG_COEF, 64'h8080_8080_8080_8080);
    write_reg(REG_GAIN, junk_high(COEF_W, -128));
    write_reg(REG_VOLUME, junk_high(VOL_W, 0));
    run_random(200);

    // one block of delay, long enough for the echo to come around
    write_reg(REG_DELAY, junk_high(DELAY_W, 1));
    write_reg(REG_COEF, {$urandom, $urandom});
    write_reg(REG_GAIN, junk_high(COEF_W, $urandom_range(0, 255)));
    write_reg(REG_VOLUME, junk_high(VOL_W, $urandom_range(64, 127)));
    run_random(700);

    // longest delay
    write_reg(REG_DELAY, junk_high(DELAY_W, 63));
    run_random(150);

    // zero delay, random taps; sender holds off mid-phase
    write_reg(REG_DELAY, junk_high(DELAY_W, 0));
    write_reg(REG_COEF, {$urandom, $urandom});
    run_random(300, 1);

    write_reg(REG_COEF, {$urandom, $urandom});
    write_reg(REG_GAIN, junk_high(COEF_W, $urandom_range(0, 255)));
    write_reg(REG_VOLUME, junk_high(VOL_W, $urandom_range(0, 127)));
    run_random(380);

    wait_drained();
    if (err_cnt == 0) begin
      $display("delayed_fir_echo_reverb_unit: match");
    end else begin
      $display("delayed_fir_echo_reverb_unit: mismatch");
    end
    $finish;
  end

endmodule

### delayed_fir_echo_reverb_unit.f
src/dfer_pkg.sv
src/dfer_ram.sv
src/dfer_mul.sv
src/delayed_fir_echo_reverb_unit.sv
verif/delayed_fir_echo_reverb_unit_tb.sv
